@@ src/lppr_pkg.sv @@
package lppr_pkg;

  // default geometry
  localparam int unsigned PANEL_W_DEF    = 32;
  localparam int unsigned PANEL_H_DEF    = 32;
  localparam int unsigned MAX_PANELS_DEF = 16;

  // field widths
  localparam int unsigned POS_W = 9;
  localparam int unsigned COL_W = 8;
  localparam int unsigned TX_W  = 8;
  localparam int unsigned TY_W  = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // command codes
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  // rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRIGHTNESS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_Y       = 3'd6;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [COL_W-1:0] red_in;
    logic [COL_W-1:0] green_in;
    logic [COL_W-1:0] blue_in;
    logic             force_req;
    logic [3:0]       panel_slot;
    logic [2:0]       panel_order;
    logic [1:0]       panel_parallel;
    logic [1:0]       panel_rotation;
  } in_word_t;

  typedef struct packed {
    logic [TX_W-1:0]  target_x;
    logic [TY_W-1:0]  target_y;
    logic [COL_W-1:0] red_out;
    logic [COL_W-1:0] green_out;
    logic [COL_W-1:0] blue_out;
  } out_word_t;

  typedef struct packed {
    logic [4:0]       grid_cols;
    logic [4:0]       grid_rows;
    logic [3:0]       chain_length;
    logic [COL_W-1:0] cutoff;
    logic [COL_W-1:0] max_brightness;
    logic             mirror_x;
    logic             mirror_y;
  } cfg_t;

  typedef struct packed {
    logic [2:0] order;
    logic [1:0] parallel;
    logic [1:0] rotation;
  } panel_ent_t;

endpackage

@@ src/lppr_map_ram.sv @@
module lppr_map_ram #(
  parameter int unsigned WORD_W = 32,
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned AW     = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lppr_xform.sv @@
module lppr_xform #(
  parameter int unsigned PANEL_W = lppr_pkg::PANEL_W_DEF,
  parameter int unsigned PANEL_H = lppr_pkg::PANEL_H_DEF,
  parameter int unsigned LXW     = 5,
  parameter int unsigned LYW     = 5
) (
  input  logic [LXW-1:0]                 lx_i,
  input  logic [LYW-1:0]                 ly_i,
  input  lppr_pkg::panel_ent_t           ent_i,
  input  lppr_pkg::cfg_t                 cfg_i,
  input  logic [lppr_pkg::COL_W-1:0]     red_i,
  input  logic [lppr_pkg::COL_W-1:0]     green_i,
  input  logic [lppr_pkg::COL_W-1:0]     blue_i,
  output lppr_pkg::out_word_t            out_word_o
);

  localparam int unsigned TXW = lppr_pkg::TX_W;
  localparam int unsigned TYW = lppr_pkg::TY_W;

  logic [TXW-1:0] rx;
  logic [TYW-1:0] ry;
  logic [TYW-1:0] my;
  logic [TXW-1:0] chain_off;
  logic [TXW-1:0] xi;
  logic [TXW-1:0] xm;

  // panel rotation in local coordinates
  always_comb begin
    rx = TXW'(lx_i);
    ry = TYW'(ly_i);
    case (ent_i.rotation)
      lppr_pkg::ROT_0: begin
        rx = TXW'(lx_i);
        ry = TYW'(ly_i);
      end
      lppr_pkg::ROT_90: begin
        rx = TXW'(PANEL_H - 1) - TXW'(ly_i);
        ry = TYW'(lx_i);
      end
      lppr_pkg::ROT_180: begin
        rx = TXW'(PANEL_W - 1) - TXW'(lx_i);
        ry = TYW'(PANEL_H - 1) - TYW'(ly_i);
      end
      lppr_pkg::ROT_270: begin
        rx = TXW'(ly_i);
        ry = TYW'(PANEL_W - 1) - TYW'(lx_i);
      end
      default: begin
        rx = TXW'(lx_i);
        ry = TYW'(ly_i);
      end
    endcase
  end

  // chain offset and mirroring, wrapping at the field widths
  always_comb begin
    chain_off = TXW'(cfg_i.chain_length) - TXW'(1) - TXW'(ent_i.order);
    xi = TXW'(chain_off * TXW'(PANEL_W)) + rx;
    xm = TXW'(TXW'(cfg_i.chain_length) * TXW'(PANEL_W)) - xi - TXW'(1);
    my = cfg_i.mirror_y ? (TYW'(PANEL_H - 1) - ry) : ry;
  end

  // result word with colors clamped
  always_comb begin
    out_word_o.target_x  = cfg_i.mirror_x ? xm : xi;
    out_word_o.target_y  = TYW'(TYW'(ent_i.parallel) * TYW'(PANEL_H)) + my;
    out_word_o.red_out   = (red_i < cfg_i.max_brightness) ? red_i : cfg_i.max_brightness;
    out_word_o.green_out = (green_i < cfg_i.max_brightness) ? green_i : cfg_i.max_brightness;
    out_word_o.blue_out  = (blue_i < cfg_i.max_brightness) ? blue_i : cfg_i.max_brightness;
  end

endmodule

@@ src/led_panel_pixel_remapper_unit.sv @@
// draw: result strobe after the stages below; no new item is taken until the draw is over
//   (stages: divide, slot, occupancy read, occupancy write-back)
// load: written on acceptance; clear: one map row a cycle over all MAX_PANELS*PANEL_H rows
// reset: config regs return to reset values, then a sweep over all MAX_PANELS*PANEL_H rows
//   zeroes the occupancy map with busy high; config writes are taken meanwhile
// results are single-cycle strobes; the receiver cannot stall
module led_panel_pixel_remapper_unit #(
  parameter int unsigned PANEL_W    = lppr_pkg::PANEL_W_DEF,
  parameter int unsigned PANEL_H    = lppr_pkg::PANEL_H_DEF,
  parameter int unsigned MAX_PANELS = lppr_pkg::MAX_PANELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  lppr_pkg::in_word_t                in_word_i,
  input  logic                              cfg_we_i,
  input  logic [lppr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lppr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                              out_strobe_o,
  output lppr_pkg::out_word_t               out_word_o
);

  localparam int unsigned POSW     = lppr_pkg::POS_W;
  localparam int unsigned LXW      = (PANEL_W > 1) ? $clog2(PANEL_W) : 1;
  localparam int unsigned LYW      = (PANEL_H > 1) ? $clog2(PANEL_H) : 1;
  localparam int unsigned TAW      = (MAX_PANELS > 1) ? $clog2(MAX_PANELS) : 1;
  localparam int unsigned MAP_ROWS = MAX_PANELS * PANEL_H;
  localparam int unsigned MAW      = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int unsigned DIV_SH   = 20;
  localparam int unsigned PRODW    = POSW + DIV_SH + 1;
  localparam int unsigned RECIP_X  = (1 << DIV_SH) / PANEL_W + 1;
  localparam int unsigned RECIP_Y  = (1 << DIV_SH) / PANEL_H + 1;
  localparam int unsigned SLOTW    = 10;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_SLOT  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_CLEAR = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  lppr_pkg::cfg_t         cfg_q;
  lppr_pkg::in_word_t     in_q;
  logic [POSW-1:0]        col_q, row_q;
  logic [SLOTW-1:0]       slot_q;
  logic [LXW-1:0]         lx_q;
  logic [LYW-1:0]         ly_q;
  logic [MAW-1:0]         clr_q, clr_d;
  logic                   out_strobe_q, out_strobe_d;
  lppr_pkg::out_word_t    out_word_q;
  lppr_pkg::out_word_t    xf_word;
  lppr_pkg::panel_ent_t   tab_mem_q [MAX_PANELS];
  lppr_pkg::panel_ent_t   tab_rd_q;

  logic                   accept;
  logic [PRODW-1:0]       col_prod, row_prod;
  logic [POSW-1:0]        col_div, row_div;
  logic [SLOTW-1:0]       slot_calc;
  logic [POSW-1:0]        lx_full, ly_full;
  logic [MAW-1:0]         map_raddr, map_waddr;
  logic [PANEL_W-1:0]     map_rd, map_wdata;
  logic                   map_we;
  logic                   hit, dim, keep;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_cols      <= 5'd1;
      cfg_q.grid_rows      <= 5'd1;
      cfg_q.chain_length   <= 4'd1;
      cfg_q.cutoff         <= 8'd0;
      cfg_q.max_brightness <= 8'd255;
      cfg_q.mirror_x       <= 1'b0;
      cfg_q.mirror_y       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lppr_pkg::CFG_GRID_COLS:      cfg_q.grid_cols      <= cfg_wdata_i[4:0];
        lppr_pkg::CFG_GRID_ROWS:      cfg_q.grid_rows      <= cfg_wdata_i[4:0];
        lppr_pkg::CFG_CHAIN_LENGTH:   cfg_q.chain_length   <= cfg_wdata_i[3:0];
        lppr_pkg::CFG_CUTOFF:         cfg_q.cutoff         <= cfg_wdata_i;
        lppr_pkg::CFG_MAX_BRIGHTNESS: cfg_q.max_brightness <= cfg_wdata_i;
        lppr_pkg::CFG_MIRROR_X:       cfg_q.mirror_x       <= cfg_wdata_i[0];
        lppr_pkg::CFG_MIRROR_Y:       cfg_q.mirror_y       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // panel table, loaded straight from the input word
  always_ff @(posedge clk_i) begin
    if (accept && (in_word_i.cmd == lppr_pkg::CMD_LOAD) &&
        (7'(in_word_i.panel_slot) < 7'(MAX_PANELS))) begin
      tab_mem_q[TAW'(in_word_i.panel_slot)] <= {in_word_i.panel_order,
                                                in_word_i.panel_parallel,
                                                in_word_i.panel_rotation};
    end
  end

  always_ff @(posedge clk_i) begin
    tab_rd_q <= tab_mem_q[slot_q[TAW-1:0]];
  end

  // panel column and row by reciprocal multiply
  always_comb begin
    col_prod = PRODW'(in_q.pos_x) * PRODW'(RECIP_X);
    row_prod = PRODW'(in_q.pos_y) * PRODW'(RECIP_Y);
    col_div  = col_prod[DIV_SH +: POSW];
    row_div  = row_prod[DIV_SH +: POSW];
  end

  // slot index and position inside the panel
  always_comb begin
    slot_calc = SLOTW'(cfg_q.grid_cols) * SLOTW'(row_q[4:0]) + SLOTW'(col_q);
    lx_full   = in_q.pos_x - POSW'(col_q * POSW'(PANEL_W));
    ly_full   = in_q.pos_y - POSW'(row_q * POSW'(PANEL_H));
  end

  // occupancy check and write-back
  assign map_raddr = MAW'(slot_q[TAW-1:0]) * MAW'(PANEL_H) + MAW'(ly_q);
  assign hit       = map_rd[lx_q];
  assign dim       = !in_q.force_req && (in_q.red_in < cfg_q.cutoff) &&
                     (in_q.green_in < cfg_q.cutoff) && (in_q.blue_in < cfg_q.cutoff);
  assign keep      = !hit && !dim;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = map_raddr;
    map_wdata = map_rd;
    if (state_q == ST_CLEAR) begin
      map_we    = 1'b1;
      map_waddr = clr_q;
      map_wdata = '0;
    end else if ((state_q == ST_WRITE) && keep) begin
      map_we          = 1'b1;
      map_wdata[lx_q] = 1'b1;
    end
  end

  lppr_map_ram #(
    .WORD_W (PANEL_W),
    .DEPTH  (MAP_ROWS),
    .AW     (MAW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rd)
  );

  lppr_xform #(
    .PANEL_W (PANEL_W),
    .PANEL_H (PANEL_H),
    .LXW     (LXW),
    .LYW     (LYW)
  ) u_xform (
    .lx_i       (lx_q),
    .ly_i       (ly_q),
    .ent_i      (tab_rd_q),
    .cfg_i      (cfg_q),
    .red_i      (in_q.red_in),
    .green_i    (in_q.green_in),
    .blue_i     (in_q.blue_in),
    .out_word_o (xf_word)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    out_strobe_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (in_word_i.cmd)
            lppr_pkg::CMD_DRAW: begin
              state_d = ST_DIV;
            end
            lppr_pkg::CMD_CLEAR: begin
              state_d = ST_CLEAR;
              clr_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if ((col_div >= POSW'(cfg_q.grid_cols)) || (row_div >= POSW'(cfg_q.grid_rows))) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SLOT;
        end
      end
      ST_SLOT: begin
        if (slot_calc >= SLOTW'(MAX_PANELS)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        out_strobe_d = keep;
        state_d      = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_q == MAW'(MAP_ROWS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + MAW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      out_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      out_strobe_q <= out_strobe_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
    if (state_q == ST_DIV) begin
      col_q <= col_div;
      row_q <= row_div;
    end
    if (state_q == ST_SLOT) begin
      slot_q <= slot_calc;
      lx_q   <= lx_full[LXW-1:0];
      ly_q   <= ly_full[LYW-1:0];
    end
    if ((state_q == ST_WRITE) && keep) begin
      out_word_q <= xf_word;
    end
  end

  assign out_strobe_o = out_strobe_q;
  assign out_word_o   = out_word_q;

  // a result only follows the write-back step of a draw
  a_strobe_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_q |-> ($past(state_q == ST_WRITE) && (in_q.cmd == lppr_pkg::CMD_DRAW)))
    else $error("result strobe without a draw write-back");

  // a pixel already marked never yields a result
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) && hit |=> !out_strobe_q)
    else $error("result for a pixel already written");

  // the map changes only during write-back or the clearing sweep
  a_map_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_we |-> ((state_q == ST_WRITE) || (state_q == ST_CLEAR)))
    else $error("map written outside write-back or clear");

  // the clearing sweep ends at the last row
  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) && (clr_q != MAW'(MAP_ROWS - 1)) |=> (state_q == ST_CLEAR))
    else $error("clear sweep left early");

endmodule

@@ tb/sv/led_panel_pixel_remapper_unit_test.sv @@
`timescale 1ns / 1ps

module led_panel_pixel_remapper_unit_test;
  import lppr_pkg::*;

  // panel geometry of the default build
  localparam int unsigned PIX_W    = PANEL_W_DEF;
  localparam int unsigned PIX_H    = PANEL_H_DEF;
  localparam int unsigned SLOTS    = MAX_PANELS_DEF;
  localparam int unsigned MAP_BITS = SLOTS * PIX_W * PIX_H;
  localparam int unsigned SETTLE   = 8;
  localparam int unsigned PHASES   = 8;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  typedef struct {
    in_word_t  w;
    bit        typed;
    bit        has;
    out_word_t exp;
  } plan_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_word_t  in_word_i;
  logic      cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic      out_strobe_o;
  out_word_t out_word_o;

  // shadow of the block state
  cfg_t       cur_cfg;
  panel_ent_t panel_tbl [SLOTS];
  bit         pixel_done [MAP_BITS];
  out_word_t  pending_words [$];

  int unsigned errors;
  int unsigned words_checked;
  int unsigned words_sent;
  int unsigned draws_dropped;
  int unsigned map_clears;
  int unsigned panel_loads;

  led_panel_pixel_remapper_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_word_i    (in_word_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_strobe_o (out_strobe_o),
    .out_word_o   (out_word_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #3_000_000;
    $display("timeout with %0d words still expected", pending_words.size());
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  function automatic logic [COL_W-1:0] clamp_level(input logic [COL_W-1:0] v);
    return (v < cur_cfg.max_brightness) ? v : cur_cfg.max_brightness;
  endfunction

  // pixel remap of one draw word, marks the occupancy shadow
  function automatic bit remap_draw(input in_word_t w, output out_word_t r);
    int unsigned px, py, row, col, slot, lx, ly, t, xi, yi, bit_idx;
    panel_ent_t  ent;
    r  = '0;
    px = w.pos_x;
    py = w.pos_y;
    if (px >= 32'(cur_cfg.grid_cols) * PIX_W || py >= 32'(cur_cfg.grid_rows) * PIX_H) begin
      return 1'b0;
    end
    row  = py / PIX_H;
    col  = px / PIX_W;
    slot = 32'(cur_cfg.grid_cols) * row + col;
    if (slot >= SLOTS) begin
      return 1'b0;
    end
    lx = px % PIX_W;
    ly = py % PIX_H;
    bit_idx = (slot * PIX_H + ly) * PIX_W + lx;
    if (pixel_done[bit_idx]) begin
      return 1'b0;
    end
    if (!w.force_req && w.red_in < cur_cfg.cutoff && w.green_in < cur_cfg.cutoff &&
        w.blue_in < cur_cfg.cutoff) begin
      return 1'b0;
    end
    pixel_done[bit_idx] = 1'b1;
    ent = panel_tbl[slot];
    // panel rotation, square panel math
    case (ent.rotation)
      ROT_90: begin
        t  = lx;
        lx = PIX_H - 1 - ly;
        ly = t;
      end
      ROT_180: begin
        lx = PIX_W - 1 - lx;
        ly = PIX_H - 1 - ly;
      end
      ROT_270: begin
        t  = ly;
        ly = PIX_W - 1 - lx;
        lx = t;
      end
      default: ;
    endcase
    // chain offset wraps with the target field
    xi = (32'(cur_cfg.chain_length) - 32'd1 - 32'(ent.order)) * PIX_W + lx;
    if (cur_cfg.mirror_x) begin
      xi = 32'(cur_cfg.chain_length) * PIX_W - xi - 32'd1;
    end
    if (cur_cfg.mirror_y) begin
      ly = PIX_H - 1 - ly;
    end
    yi = 32'(ent.parallel) * PIX_H + ly;
    r.target_x  = TX_W'(xi);
    r.target_y  = TY_W'(yi);
    r.red_out   = clamp_level(w.red_in);
    r.green_out = clamp_level(w.green_in);
    r.blue_out  = clamp_level(w.blue_in);
    return 1'b1;
  endfunction

  function automatic in_word_t rand_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t mk_draw(input int unsigned x, input int unsigned y,
                                       input int unsigned r, input int unsigned g,
                                       input int unsigned b, input bit f);
    in_word_t w;
    w = '0;
    w.cmd       = CMD_DRAW;
    w.pos_x     = x;
    w.pos_y     = y;
    w.red_in    = r;
    w.green_in  = g;
    w.blue_in   = b;
    w.force_req = f;
    return w;
  endfunction

  function automatic in_word_t mk_load(input int unsigned slot, input int unsigned order,
                                       input int unsigned par, input logic [1:0] rot);
    in_word_t w;
    w = '0;
    w.cmd            = CMD_LOAD;
    w.panel_slot     = slot;
    w.panel_order    = order;
    w.panel_parallel = par;
    w.panel_rotation = rot;
    return w;
  endfunction

  function automatic out_word_t word_at(input int unsigned x, input int unsigned y,
                                        input int unsigned r, input int unsigned g,
                                        input int unsigned b);
    out_word_t o;
    o.target_x  = x;
    o.target_y  = y;
    o.red_out   = r;
    o.green_out = g;
    o.blue_out  = b;
    return o;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one word, track its effect at the accepting edge
  task automatic send_word(input in_word_t w, input bit typed, input bit typed_has,
                           input out_word_t typed_exp);
    out_word_t pred;
    bit        has;
    start     <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    words_sent++;
    has  = 1'b0;
    pred = '0;
    case (w.cmd)
      CMD_DRAW: begin
        has = remap_draw(w, pred);
        if (!has) draws_dropped++;
      end
      CMD_CLEAR: begin
        pixel_done = '{default: 1'b0};
        map_clears++;
      end
      CMD_LOAD: begin
        panel_tbl[w.panel_slot] = '{w.panel_order, w.panel_parallel, w.panel_rotation};
        panel_loads++;
      end
      default: ;
    endcase
    if (typed) begin
      has  = typed_has;
      pred = typed_exp;
    end
    if (has) pending_words.push_back(pred);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold off until every word is back and the block is quiet
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input cfg_t c);
    cfg_we_i <= 1'b1;
    put_reg(CFG_GRID_COLS,      CFG_DATA_W'(c.grid_cols));
    put_reg(CFG_GRID_ROWS,      CFG_DATA_W'(c.grid_rows));
    put_reg(CFG_CHAIN_LENGTH,   CFG_DATA_W'(c.chain_length));
    put_reg(CFG_CUTOFF,         c.cutoff);
    put_reg(CFG_MAX_BRIGHTNESS, c.max_brightness);
    put_reg(CFG_MIRROR_X,       CFG_DATA_W'(c.mirror_x));
    put_reg(CFG_MIRROR_Y,       CFG_DATA_W'(c.mirror_y));
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  // pick a pixel, mostly on a panel that the table covers
  task automatic pick_pixel(output logic [POS_W-1:0] px, output logic [POS_W-1:0] py);
    int unsigned cols, span, s;
    cols = cur_cfg.grid_cols;
    span = cols * cur_cfg.grid_rows;
    if (span == 0 || $urandom_range(0, 4) == 0) begin
      px = $urandom_range(0, 511);
      py = $urandom_range(0, 511);
    end else begin
      s  = $urandom_range(0, ((span < SLOTS) ? span : SLOTS) - 1);
      px = (s % cols) * PIX_W + $urandom_range(0, PIX_W - 1);
      py = (s / cols) * PIX_H + $urandom_range(0, PIX_H - 1);
    end
  endtask

  // output word check against the oldest expectation
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni === 1'b1 && out_strobe_o !== 1'b0) begin
      if (out_strobe_o !== 1'b1) begin
        report_mismatch("output strobe unknown");
      end else if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0h", out_word_o));
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        check_field("target_x",  out_word_o.target_x,  want.target_x);
        check_field("target_y",  out_word_o.target_y,  want.target_y);
        check_field("red_out",   out_word_o.red_out,   want.red_out);
        check_field("green_out", out_word_o.green_out, want.green_out);
        check_field("blue_out",  out_word_o.blue_out,  want.blue_out);
      end
    end
  end

  // stimulus
  initial begin
    plan_row_t   plan [$];
    cfg_t        phase_cfg [PHASES];
    int unsigned phase_len [PHASES];
    logic [2*POS_W-1:0] recent_px [$];
    in_word_t    w;
    logic [POS_W-1:0] px, py;
    int unsigned n, r, bx, by, pick;
    bit          fill_done;
    bit          quiet;

    errors        = 0;
    words_checked = 0;
    words_sent    = 0;
    draws_dropped = 0;
    map_clears    = 0;
    panel_loads   = 0;
    cur_cfg       = '{5'd1, 5'd1, 4'd1, 8'd0, 8'd255, 1'b0, 1'b0};
    pixel_done    = '{default: 1'b0};
    foreach (panel_tbl[i]) panel_tbl[i] = '0;

    rst_ni      = 1'b0;
    start       = 1'b0;
    in_word_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words on the reset settings: one panel, chain of one
    plan.push_back('{mk_load(0, 0, 0, ROT_0), 1'b0, 1'b0, '0});
    plan.push_back('{mk_draw(0, 0, 255, 255, 255, 0), 1'b1, 1'b1, word_at(0, 0, 255, 255, 255)});
    plan.push_back('{mk_draw(31, 31, 0, 0, 0, 0), 1'b1, 1'b1, word_at(31, 31, 0, 0, 0)});
    // pixel already written, even when forced
    plan.push_back('{mk_draw(0, 0, 9, 9, 9, 1), 1'b1, 1'b0, '0});
    // off the canvas
    plan.push_back('{mk_draw(32, 0, 50, 50, 50, 1), 1'b1, 1'b0, '0});
    plan.push_back('{mk_draw(511, 511, 50, 50, 50, 1), 1'b1, 1'b0, '0});
    plan.push_back('{mk_draw(0, 511, 50, 50, 50, 1), 1'b1, 1'b0, '0});
    // each rotation
    plan.push_back('{mk_load(0, 0, 0, ROT_90), 1'b0, 1'b0, '0});
    plan.push_back('{mk_draw(5, 3, 1, 2, 3, 0), 1'b1, 1'b1, word_at(28, 5, 1, 2, 3)});
    plan.push_back('{mk_load(0, 0, 0, ROT_180), 1'b0, 1'b0, '0});
    plan.push_back('{mk_draw(7, 9, 128, 64, 32, 1), 1'b1, 1'b1, word_at(24, 22, 128, 64, 32)});
    plan.push_back('{mk_load(0, 0, 0, ROT_270), 1'b0, 1'b0, '0});
    plan.push_back('{mk_draw(10, 4, 10, 20, 30, 0), 1'b1, 1'b1, word_at(4, 21, 10, 20, 30)});
    // order past the chain wraps the x offset, top parallel chain
    plan.push_back('{mk_load(0, 7, 3, ROT_0), 1'b0, 1'b0, '0});
    plan.push_back('{mk_draw(2, 1, 255, 0, 255, 0), 1'b1, 1'b1, word_at(34, 97, 255, 0, 255)});
    w = rand_word();
    w.cmd = CMD_UNUSED;
    plan.push_back('{w, 1'b1, 1'b0, '0});
    w = rand_word();
    w.cmd = CMD_CLEAR;
    plan.push_back('{w, 1'b1, 1'b0, '0});
    // map cleared, same pixel comes out again
    plan.push_back('{mk_draw(0, 0, 200, 100, 50, 0), 1'b1, 1'b1, word_at(32, 96, 200, 100, 50)});
    plan.push_back('{mk_load(15, 5, 2, ROT_270), 1'b0, 1'b0, '0});
    plan.push_back('{mk_draw(31, 0, 7, 7, 7, 0), 1'b1, 1'b1, word_at(63, 96, 7, 7, 7)});

    foreach (plan[i]) begin
      send_word(plan[i].w, plan[i].typed, plan[i].has, plan[i].exp);
      pause_sender(gap_len());
    end
    wait_idle();

    // fill the whole panel table before random draws
    for (int s = 0; s < SLOTS; s++) begin
      w = rand_word();
      w.cmd        = CMD_LOAD;
      w.panel_slot = s;
      send_word(w, 1'b0, 1'b0, '0);
      pause_sender(gap_len());
    end

    // register settings, extremes first
    phase_cfg[0] = '{5'd16, 5'd16, 4'd8, 8'd255, 8'd0, 1'b1, 1'b1};
    phase_cfg[1] = '{5'd4, 5'd4, 4'd4, 8'd128, 8'd128, 1'b0, 1'b1};
    phase_cfg[2] = '{5'd31, 5'd31, 4'd15, 8'd1, 8'd254, 1'b1, 1'b0};
    phase_cfg[3] = '{5'd0, 5'd3, 4'd0, 8'd10, 8'd200, 1'b0, 1'b0};
    phase_cfg[4] = '{5'd2, 5'd8, 4'd0, 8'd64, 8'd100, 1'b1, 1'b1};
    phase_len    = '{90, 90, 80, 10, 90, 85, 85, 85};
    for (int p = 5; p < PHASES; p++) begin
      phase_cfg[p].grid_cols      = $urandom_range(1, 16);
      phase_cfg[p].grid_rows      = $urandom_range(1, 16);
      phase_cfg[p].chain_length   = $urandom_range(1, 8);
      phase_cfg[p].cutoff         = $urandom_range(0, 255);
      phase_cfg[p].max_brightness = $urandom_range(0, 255);
      phase_cfg[p].mirror_x       = $urandom_range(0, 1);
      phase_cfg[p].mirror_y       = $urandom_range(0, 1);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      apply_cfg(phase_cfg[p]);
      fill_done = 1'b0;
      quiet     = (p == 1);
      n         = 0;
      while (n < phase_len[p]) begin
        r = $urandom_range(0, 99);
        w = rand_word();
        if (r < 4) begin
          w.cmd = CMD_CLEAR;
          send_word(w, 1'b0, 1'b0, '0);
          recent_px.delete();
          n++;
        end else if (r < 12) begin
          w.cmd = CMD_LOAD;
          send_word(w, 1'b0, 1'b0, '0);
          n++;
        end else if (r < 14) begin
          w.cmd = CMD_UNUSED;
          send_word(w, 1'b0, 1'b0, '0);
        end else if (r < 17 && !fill_done && cur_cfg.grid_cols != 0) begin
          // fill-remaining on a small block: forced draws, then a clear
          pick_pixel(px, py);
          bx = (px > 508) ? 508 : px;
          by = (py > 508) ? 508 : py;
          for (int dy = 0; dy < 4; dy++) begin
            for (int dx = 0; dx < 4; dx++) begin
              w = rand_word();
              w.cmd       = CMD_DRAW;
              w.pos_x     = bx + dx;
              w.pos_y     = by + dy;
              w.force_req = 1'b1;
              send_word(w, 1'b0, 1'b0, '0);
              if (!quiet) pause_sender(gap_len());
            end
          end
          w = rand_word();
          w.cmd = CMD_CLEAR;
          send_word(w, 1'b0, 1'b0, '0);
          recent_px.delete();
          fill_done = 1'b1;
          n += 17;
        end else begin
          w.cmd = CMD_DRAW;
          if (r < 27 && recent_px.size() != 0) begin
            pick = $urandom_range(0, recent_px.size() - 1);
            {px, py} = recent_px[pick];
          end else begin
            pick_pixel(px, py);
          end
          w.pos_x     = px;
          w.pos_y     = py;
          w.force_req = ($urandom_range(0, 3) == 0);
          // colors near the cutoff so the skip test fires
          if ($urandom_range(0, 2) == 0) begin
            w.red_in   = $urandom_range(0, cur_cfg.cutoff);
            w.green_in = $urandom_range(0, cur_cfg.cutoff);
            w.blue_in  = $urandom_range(0, cur_cfg.cutoff);
          end
          send_word(w, 1'b0, 1'b0, '0);
          recent_px.push_back({px, py});
          if (recent_px.size() > 8) void'(recent_px.pop_front());
          n++;
        end
        if (!quiet) pause_sender(gap_len());
      end
    end

    wait_idle();
    $display("covered %0d words over %0d register settings, %0d output words checked",
             words_sent, PHASES + 1, words_checked);
    $display("dropped draws %0d, map clears %0d, panel loads %0d",
             draws_dropped, map_clears, panel_loads);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
